// ===== design/uvp_pkg.sv =====
`default_nettype none

package uvp_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // angle in half-turns with 24 fractional bits
  localparam int ANG_FRAC = 24;
  localparam int ANG_W    = 28;
  localparam int TAB_LEN  = 24;

  // rescaled operands are about 2^29 in magnitude
  localparam int SC_W       = 31;
  localparam int CW         = 34;
  localparam int SQ_W       = 60;
  localparam int RT_W       = 30;
  localparam int REM_W      = 34;
  localparam int SQRT_STEPS = SQ_W / 2;

  localparam int MODE_W     = 2;
  localparam int TOL_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_TOL = 1'b1;

  localparam logic signed [ANG_W-1:0] ANG_HALF = 28'sd8388608;
  localparam logic signed [ANG_W-1:0] ANG_ONE  = 28'sd16777216;

  typedef enum logic [MODE_W-1:0] {
    MODE_SPHERE   = 2'd0,
    MODE_PLANE    = 2'd1,
    MODE_CYLINDER = 2'd2,
    MODE_BOX      = 2'd3
  } map_mode_e;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] ang;
    logic                    skip;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
    logic [SQ_W-1:0]  rad;
  } sqrt_t;

  // round(2^24 * atan(2^-i) / pi)
  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] e;
    case (idx)
      0:  e = 28'sd4194304;
      1:  e = 28'sd2476042;
      2:  e = 28'sd1308273;
      3:  e = 28'sd664100;
      4:  e = 28'sd333339;
      5:  e = 28'sd166832;
      6:  e = 28'sd83436;
      7:  e = 28'sd41721;
      8:  e = 28'sd20861;
      9:  e = 28'sd10430;
      10: e = 28'sd5215;
      11: e = 28'sd2608;
      12: e = 28'sd1304;
      13: e = 28'sd652;
      14: e = 28'sd326;
      15: e = 28'sd163;
      16: e = 28'sd81;
      17: e = 28'sd41;
      18: e = 28'sd20;
      19: e = 28'sd10;
      20: e = 28'sd5;
      21: e = 28'sd3;
      22: e = 28'sd1;
      23: e = 28'sd1;
      default: e = 28'sd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== design/uv_texture_projection.sv =====
`default_nettype none

// Maps one local-space hit point (x, y, z), signed fixed point with four integer
// bits, to texture coordinates (u, v) under the projection in map_mode: sphere,
// plane, cylinder or box. Angles come from two rows of vectoring CORDIC cells
// (one for atan2(y, x), one for atan2(sqrt(x^2 + y^2), z)) with a row of
// 30 square-root digit cells between them. A new point is taken every cycle
// while the output side keeps up; the longest path runs through the square-root
// row and the second CORDIC row in series. The whole pipeline holds when a
// result waits unread.
// Write map_mode and face_tolerance only while no point is in flight.
module uv_texture_projection import uvp_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      u_coord_o,
  output logic signed [COORD_WIDTH-1:0]      v_coord_o
);

  localparam int W    = COORD_WIDTH;
  localparam int FRAC = W - 4;
  localparam int NST  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // input rescale by 2^(30-W), rounding half up when it is a right shift
  localparam int PRE_SHIFT = 30 - W;
  localparam int IN_LSH    = (PRE_SHIFT > 0) ? PRE_SHIFT : 0;
  localparam int IN_RSH    = (PRE_SHIFT < 0) ? -PRE_SHIFT : 0;
  localparam int IN_RND    = (IN_RSH > 0) ? (1 << (IN_RSH - 1)) : 0;
  localparam int IN_XW     = SC_W + W;

  // angle to output format
  localparam int A_LSH = (FRAC > ANG_FRAC) ? FRAC - ANG_FRAC : 0;
  localparam int A_RSH = (FRAC < ANG_FRAC) ? ANG_FRAC - FRAC : 0;
  localparam int A_RND = (A_RSH > 0) ? (1 << (A_RSH - 1)) : 0;
  localparam int AO_W  = ANG_W + 6;
  localparam logic signed [AO_W-1:0] AO_MAX = AO_W'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [AO_W-1:0] AO_MIN = AO_W'(-(longint'(1) <<< (W - 1)));

  // box terms
  localparam int QW = W + 4;
  localparam int NW = W + TOL_W;
  localparam logic signed [QW-1:0] ONE_Q   = QW'(longint'(1) <<< FRAC);
  localparam logic signed [NW-1:0] ONE_N   = NW'(longint'(1) <<< FRAC);
  localparam logic signed [QW-1:0] Q_MAX   = QW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN   = QW'(-(longint'(1) <<< (W - 1)));
  localparam logic signed [W-1:0]  OUT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  OUT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [QW-1:0] TWO_Q   = QW'(2);
  localparam logic signed [QW-1:0] THREE_Q = QW'(3);

  // pipeline depths, counted in registers from the input side
  localparam int SQ_DLY  = 2 + SQRT_STEPS;
  localparam int D1      = 2 + NST;
  localparam int D2      = 2 + SQ_DLY + NST;
  localparam int ANG_DLY = D2 - D1;
  localparam int DIR_DLY = D2 - 1;
  localparam int LAT     = D2 + 1;

  function automatic logic signed [SC_W-1:0] rescale_in(input logic signed [W-1:0] v);
    logic signed [IN_XW-1:0] t;
    t = {{SC_W{v[W-1]}}, v};
    t = ((t <<< IN_LSH) + IN_XW'(IN_RND)) >>> IN_RSH;
    return t[SC_W-1:0];
  endfunction

  function automatic logic signed [W-1:0] angle_out(input logic signed [ANG_W:0] a);
    logic signed [AO_W-1:0] t;
    t = {{(AO_W-ANG_W-1){a[ANG_W]}}, a};
    t = ((t <<< A_LSH) + AO_W'(A_RND)) >>> A_RSH;
    if (t > AO_MAX) begin
      return OUT_MAX;
    end else if (t < AO_MIN) begin
      return OUT_MIN;
    end
    return t[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] quarter(input logic signed [QW-1:0] t);
    logic signed [QW-1:0] q;
    q = (t + QW'(2)) >>> 2;
    if (q > Q_MAX) begin
      return OUT_MAX;
    end else if (q < Q_MIN) begin
      return OUT_MIN;
    end
    return q[W-1:0];
  endfunction

  function automatic logic near_face(input logic signed [W-1:0] c, input logic neg_face,
                                     input logic [TOL_W-1:0] tol);
    logic signed [NW-1:0] d;
    d = {{TOL_W{c[W-1]}}, c};
    d = neg_face ? d + ONE_N : d - ONE_N;
    if (d < 0) begin
      d = -d;
    end
    return d < $signed({{(NW-TOL_W){1'b0}}, tol});
  endfunction

  // ---------------------------------------------------------------- control
  map_mode_e        mode_q;
  logic [TOL_W-1:0] tol_q;
  logic             en;
  logic             vld_q [LAT];

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SPHERE;
      tol_q  <= TOL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAP_MODE: mode_q <= map_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_FACE_TOL: tol_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------- input stage
  logic signed [W-1:0] du_d, dv_d, du_q, dv_q, nz;
  logic signed [QW-1:0] xq, yq, zq;
  logic signed [SC_W-1:0] sx_q, sy_q, sz_q;
  map_mode_e mode_s0_q;

  assign xq = {{4{point_x_i[W-1]}}, point_x_i};
  assign yq = {{4{point_y_i[W-1]}}, point_y_i};
  assign zq = {{4{point_z_i[W-1]}}, point_z_i};
  assign nz = (point_z_i == OUT_MIN) ? OUT_MAX : -point_z_i;

  always_comb begin
    du_d = '0;
    dv_d = '0;
    unique case (mode_q)
      MODE_PLANE: begin
        du_d = point_x_i;
        dv_d = point_y_i;
      end
      MODE_CYLINDER: begin
        dv_d = nz;
      end
      MODE_BOX: begin
        // first matching face wins, in fixed face order
        priority if (near_face(point_x_i, 1'b1, tol_q)) begin
          du_d = quarter(-yq - THREE_Q * ONE_Q);
          dv_d = quarter(-zq);
        end else if (near_face(point_x_i, 1'b0, tol_q)) begin
          du_d = quarter(yq + ONE_Q);
          dv_d = quarter(-zq);
        end else if (near_face(point_y_i, 1'b1, tol_q)) begin
          du_d = quarter(xq - ONE_Q);
          dv_d = quarter(-zq - TWO_Q * ONE_Q);
        end else if (near_face(point_y_i, 1'b0, tol_q)) begin
          du_d = quarter(-xq - ONE_Q);
          dv_d = quarter(-zq + TWO_Q * ONE_Q);
        end else if (near_face(point_z_i, 1'b1, tol_q)) begin
          du_d = quarter(xq + THREE_Q * ONE_Q);
          dv_d = quarter(yq);
        end else if (near_face(point_z_i, 1'b0, tol_q)) begin
          du_d = quarter(xq - ONE_Q);
          dv_d = quarter(yq);
        end else begin
          du_d = '0;
          dv_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q      <= rescale_in(point_x_i);
      sy_q      <= rescale_in(point_y_i);
      sz_q      <= rescale_in(point_z_i);
      du_q      <= du_d;
      dv_q      <= dv_d;
      mode_s0_q <= mode_q;
    end
  end

  // ---------------------------------------------------- atan2(y, x) row
  cordic_t c1 [NST+1];

  uvp_cordic_pre u_pre1 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ({{(CW-SC_W){sy_q[SC_W-1]}}, sy_q}),
    .x_i   ({{(CW-SC_W){sx_q[SC_W-1]}}, sx_q}),
    .c_o   (c1[0])
  );

  for (genvar i = 0; i < NST; i++) begin : g_row1
    uvp_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .c_i   (c1[i]),
      .c_o   (c1[i+1])
    );
  end

  // ------------------------------------------------- radius: x^2 + y^2
  logic signed [2*SC_W-1:0] px_q, py_q;
  logic [SQ_W-1:0] sq_q;
  sqrt_t s [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= sx_q * sx_q;
      py_q <= sy_q * sy_q;
      sq_q <= px_q[SQ_W-1:0] + py_q[SQ_W-1:0];
    end
  end

  assign s[0] = '{rem: '0, root: '0, rad: sq_q};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    uvp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .s_i   (s[j]),
      .s_o   (s[j+1])
    );
  end

  // ------------------------------------------------ atan2(r, z) row
  logic [SC_W-1:0] sz_dly;
  cordic_t c2 [NST+1];

  uvp_delay #(.WIDTH(SC_W), .DEPTH(SQ_DLY)) u_dly_z (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sz_q),
    .d_o   (sz_dly)
  );

  uvp_cordic_pre u_pre2 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   ({{(CW-RT_W){1'b0}}, s[SQRT_STEPS].root}),
    .x_i   ({{(CW-SC_W){sz_dly[SC_W-1]}}, sz_dly}),
    .c_o   (c2[0])
  );

  for (genvar i = 0; i < NST; i++) begin : g_row2
    uvp_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .c_i   (c2[i]),
      .c_o   (c2[i+1])
    );
  end

  // --------------------------------------------------- align and output
  logic [ANG_W-1:0] ang1_dly;
  logic [2*W+MODE_W-1:0] dir_dly;
  logic signed [W-1:0] du_al, dv_al, u_d, v_d, u_q, v_q;
  logic signed [ANG_W-1:0] ang1, ang2;
  map_mode_e mode_al;

  uvp_delay #(.WIDTH(ANG_W), .DEPTH(ANG_DLY)) u_dly_ang (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (c1[NST].ang),
    .d_o   (ang1_dly)
  );

  uvp_delay #(.WIDTH(2*W+MODE_W), .DEPTH(DIR_DLY)) u_dly_dir (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({du_q, dv_q, mode_s0_q}),
    .d_o   (dir_dly)
  );

  assign du_al   = dir_dly[2*W+MODE_W-1 -: W];
  assign dv_al   = dir_dly[W+MODE_W-1 -: W];
  assign mode_al = map_mode_e'(dir_dly[MODE_W-1:0]);
  assign ang1    = ang1_dly;
  assign ang2    = c2[NST].ang;

  always_comb begin
    u_d = du_al;
    v_d = dv_al;
    unique case (mode_al)
      MODE_SPHERE: begin
        u_d = angle_out({ang1[ANG_W-1], ang1});
        v_d = angle_out($signed({ang2, 1'b0}) - {ANG_ONE[ANG_W-1], ANG_ONE});
      end
      MODE_CYLINDER: begin
        u_d = angle_out({ang1[ANG_W-1], ang1});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  assign u_coord_o = u_q;
  assign v_coord_o = v_q;

endmodule

`default_nettype wire

// ===== design/uvp_delay.sv =====
`default_nettype none

module uvp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign d_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/uvp_cordic_pre.sv =====
`default_nettype none

module uvp_cordic_pre import uvp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] x_i,
  output cordic_t                   c_o
);

  cordic_t c_d, c_q;

  // fold the left half plane into the right one by a quarter turn
  always_comb begin
    c_d.x   = x_i;
    c_d.y   = y_i;
    c_d.ang = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        c_d.x   = y_i;
        c_d.y   = -x_i;
        c_d.ang = ANG_HALF;
      end else begin
        c_d.x   = -y_i;
        c_d.y   = x_i;
        c_d.ang = -ANG_HALF;
      end
    end
    // zero y: angle is final, bypass the rotations
    c_d.skip = (c_d.y == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

`default_nettype wire

// ===== design/uvp_cordic_cell.sv =====
`default_nettype none

module uvp_cordic_cell import uvp_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic    clk_i,
  input  wire logic    en_i,
  input  wire cordic_t c_i,
  output cordic_t      c_o
);

  logic signed [CW-1:0] dx, dy;
  cordic_t c_d, c_q;

  assign dx = $signed(c_i.y) >>> IDX;
  assign dy = $signed(c_i.x) >>> IDX;

  always_comb begin
    c_d = c_i;
    if (!c_i.skip) begin
      if ($signed(c_i.y) > 0) begin
        c_d.x   = c_i.x + dx;
        c_d.y   = c_i.y - dy;
        c_d.ang = c_i.ang + atan_entry(IDX);
      end else begin
        c_d.x   = c_i.x - dx;
        c_d.y   = c_i.y + dy;
        c_d.ang = c_i.ang - atan_entry(IDX);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

`default_nettype wire

// ===== design/uvp_sqrt_cell.sv =====
`default_nettype none

module uvp_sqrt_cell import uvp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire sqrt_t s_i,
  output sqrt_t      s_o
);

  logic [REM_W-1:0] rem_n, trial;
  sqrt_t s_d, s_q;

  // bring down the next two radicand bits and try root digit one
  assign rem_n = {s_i.rem[REM_W-3:0], s_i.rad[SQ_W-1 -: 2]};
  assign trial = {{(REM_W-RT_W-2){1'b0}}, s_i.root, 2'b01};

  always_comb begin
    s_d.rad = {s_i.rad[SQ_W-3:0], 2'b00};
    if (rem_n >= trial) begin
      s_d.rem  = rem_n - trial;
      s_d.root = {s_i.root[RT_W-2:0], 1'b1};
    end else begin
      s_d.rem  = rem_n;
      s_d.root = {s_i.root[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import uvp_pkg::*;

  localparam int CW16 = 16;
  localparam int FRAC = CW16 - 4;
  localparam int PRE = 30 - CW16;
  localparam int STAGES = (CORDIC_STAGES_DEF < TAB_LEN) ? CORDIC_STAGES_DEF : TAB_LEN;
  localparam int LATENCY = 35 + STAGES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ONE = 1 << FRAC;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW16-1:0] point_x_i = '0;
  logic signed [CW16-1:0] point_y_i = '0;
  logic signed [CW16-1:0] point_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW16-1:0] u_coord_o;
  logic signed [CW16-1:0] v_coord_o;

  typedef struct packed {
    logic signed [CW16-1:0] u;
    logic signed [CW16-1:0] v;
  } uv_t;

  uv_t uv_expected[$];
  map_mode_e cur_mode = MODE_SPHERE;
  int unsigned cur_tol = 1;
  int mismatches = 0;
  int idle_cycles = 0;
  bit rx_idling = 1'b1;
  bit tx_idling = 1'b1;
  int rx_hold = 0;
  int rx_gap = 0;

  uv_texture_projection uut (.*);

  initial forever #1 clk_i = ~clk_i;

  function automatic longint floor_shr(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint clamp16(longint a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return a;
  endfunction

  function automatic longint half_turns(longint y, longint x);
    longint ang, dx, dy, t;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = longint'(1) <<< (ANG_FRAC - 1);
      end else begin
        x = -y; y = t; ang = -(longint'(1) <<< (ANG_FRAC - 1));
      end
    end
    if (y == 0) return ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(atan_entry(i));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_entry(i));
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint angle_to_coord(longint ang);
    int s;
    s = ANG_FRAC - FRAC;
    return clamp16(floor_shr(ang + (longint'(1) <<< (s - 1)), s));
  endfunction

  function automatic bit on_face(longint c, longint f);
    longint d;
    d = c - f;
    if (d < 0) d = -d;
    return d < longint'(cur_tol);
  endfunction

  function automatic longint quarter_scale(longint t);
    return clamp16(floor_shr(t + 2, 2));
  endfunction

  function automatic uv_t project_point(logic signed [CW16-1:0] px,
                                        logic signed [CW16-1:0] py,
                                        logic signed [CW16-1:0] pz);
    longint x, y, z, sx, sy, sz, u, v, r;
    uv_t res;
    x = px; y = py; z = pz;
    u = 0; v = 0;
    case (cur_mode)
      MODE_SPHERE, MODE_CYLINDER: begin
        sx = x <<< PRE; sy = y <<< PRE; sz = z <<< PRE;
        u = angle_to_coord(half_turns(sy, sx));
        if (cur_mode == MODE_SPHERE) begin
          r = floor_sqrt(longint'(sx * sx + sy * sy));
          v = angle_to_coord(2 * half_turns(r, sz) - (longint'(1) <<< ANG_FRAC));
        end else v = clamp16(-z);
      end
      MODE_PLANE: begin
        u = x; v = y;
      end
      default: begin
        if (on_face(x, -ONE)) begin
          u = quarter_scale(-y - 3 * ONE); v = quarter_scale(-z);
        end else if (on_face(x, ONE)) begin
          u = quarter_scale(y + ONE); v = quarter_scale(-z);
        end else if (on_face(y, -ONE)) begin
          u = quarter_scale(x - ONE); v = quarter_scale(-z - 2 * ONE);
        end else if (on_face(y, ONE)) begin
          u = quarter_scale(-x - ONE); v = quarter_scale(-z + 2 * ONE);
        end else if (on_face(z, -ONE)) begin
          u = quarter_scale(x + 3 * ONE); v = quarter_scale(y);
        end else if (on_face(z, ONE)) begin
          u = quarter_scale(x - ONE); v = quarter_scale(y);
        end
      end
    endcase
    res.u = u[CW16-1:0];
    res.v = v[CW16-1:0];
    return res;
  endfunction

  // compare each result beat against the oldest prediction
  always @(posedge clk_i) begin
    uv_t want;
    if (out_valid_o && out_ready_i) begin
      if (uv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result u=%0d v=%0d", u_coord_o, v_coord_o);
      end else begin
        want = uv_expected.pop_front();
        if (want.u !== u_coord_o || want.v !== v_coord_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mode %0d: expected u=%0d v=%0d, got u=%0d v=%0d",
                     cur_mode, want.u, want.v, u_coord_o, v_coord_o);
        end
      end
    end
  end

  // receiver: random stall bursts, or a long hold when requested
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idling && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up after the accepting edge; the next beat, a gap or drain moves it
  task automatic send_point(logic signed [CW16-1:0] x, logic signed [CW16-1:0] y,
                            logic signed [CW16-1:0] z);
    int gap;
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    uv_expected.push_back(project_point(x, y, z));
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (uv_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAP_MODE) cur_mode = map_mode_e'(value[MODE_W-1:0]);
    else cur_tol = value[TOL_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic logic signed [CW16-1:0] near_unit();
    int off;
    off = $urandom_range(0, 40) - 20;
    return logic'($urandom_range(0, 1)) ? CW16'(ONE + off) : CW16'(-ONE + off);
  endfunction

  task automatic test_directed;
    logic signed [CW16-1:0] ext[6];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh1000, -16'sh1000, 16'shffff};
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MAP_MODE, m);
      send_point(0, 0, 0);
      send_point(16'sh1000, 0, 16'sh0800);
      send_point(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                 ext[$urandom_range(0, 5)]);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(-16'sh1000, 0, 16'sh8000);
      drain();
    end
    // box faces one by one in priority order, plus a point that misses all faces
    send_point(-16'sh1000, 16'sh1000, 16'sh1000);
    send_point(16'sh1000, -16'sh1000, 0);
    send_point(0, -16'sh1000, 16'sh1000);
    send_point(0, 16'sh1000, 16'sh0500);
    send_point(16'sh0300, 0, -16'sh1000);
    send_point(16'sh0300, 0, 16'sh1000);
    send_point(16'sh0300, 16'sh0200, 16'sh0100);
    drain();
    write_reg(REG_FACE_TOL, 0);
    send_point(16'sh1000, 16'sh1000, 16'sh1000);
    drain();
  endtask

  task automatic test_random(int count, bit idling);
    logic signed [CW16-1:0] x, y, z;
    tx_idling = idling;
    rx_idling = idling;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        drain();
        write_reg(REG_MAP_MODE, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: write_reg(REG_FACE_TOL, 1);
          1: write_reg(REG_FACE_TOL, 4095);
          default: write_reg(REG_FACE_TOL, $urandom_range(1, 64));
        endcase
      end
      x = $urandom; y = $urandom; z = $urandom;
      if (cur_mode == MODE_BOX && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0: x = near_unit();
          1: y = near_unit();
          default: z = near_unit();
        endcase
      end else if ($urandom_range(0, 3) == 0) begin
        x = $urandom_range(0, 1) ? 16'sh0000 : x;
        y = $urandom_range(0, 1) ? 16'sh0000 : y;
      end
      send_point(x, y, z);
    end
    drain();
  endtask

  task automatic test_backpressure;
    tx_idling = 1'b0;
    rx_hold = 300;
    for (int i = 0; i < 90; i++) send_point($urandom, $urandom, $urandom);
    drain();
    tx_idling = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(200, 1'b1);
    test_random(100, 1'b0);
    if (mismatches == 0 && uv_expected.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
